>>> design/three_band_iir_crossover_top_macros.svh
// Assertion macros shared by the crossover checker.
`ifndef THREE_BAND_IIR_CROSSOVER_TOP_MACROS_SVH
`define THREE_BAND_IIR_CROSSOVER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define TBCX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define TBCX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tbcx_pkg.sv
// Shared widths and register codes for the three-band crossover.
`timescale 1ns / 1ps

package tbcx_pkg;

  // Fixed field and datapath widths
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 32;
  localparam int DELAY_BITS  = 48;
  localparam int TERM_BITS   = 52;
  localparam int PROD_BITS   = COEF_BITS + SAMPLE_BITS;
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_LOW_FB1      = 3'd0,
    REG_LOW_FB2      = 3'd1,
    REG_LOW_LP_GAIN  = 3'd2,
    REG_LOW_HP_GAIN  = 3'd3,
    REG_HIGH_FB1     = 3'd4,
    REG_HIGH_FB2     = 3'd5,
    REG_HIGH_LP_GAIN = 3'd6,
    REG_HIGH_HP_GAIN = 3'd7
  } cfg_reg_t;

endpackage

>>> design/tbcx_stream_if.sv
// Valid/ready channel interfaces for the crossover sample input and band output.
`timescale 1ns / 1ps

interface tbcx_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [tbcx_pkg::SAMPLE_BITS-1:0] audio_in;

  modport source (output valid, output audio_in, input ready);
  modport sink   (input valid, input audio_in, output ready);
endinterface

interface tbcx_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [tbcx_pkg::SAMPLE_BITS-1:0] low_band;
  logic signed [tbcx_pkg::SAMPLE_BITS-1:0] mid_band;
  logic signed [tbcx_pkg::SAMPLE_BITS-1:0] high_band;

  modport source (output valid, output low_band, output mid_band, output high_band,
                  input ready);
  modport sink   (input valid, input low_band, input mid_band, input high_band,
                  output ready);
endinterface

>>> design/three_band_iir_crossover_top.sv
// Three-band crossover: sixteen-section biquad cascade run on one shared multiplier.
// Usage:
//   in_ch  : one signed sample per transfer (audio_in).
//   out_ch : one transfer per input sample carrying low_band, mid_band, high_band.
//   cfg_*  : write-only coefficient port, cfg_idx selects one of eight Q2.30
//            registers; write only while no sample is in flight.
// Timing: a sample is taken only while the sequencer is idle. Each section runs
//   six steps (row read, b0 product, output, a1 product, a2 product, write-back),
//   and the sections run one after another. A new sample is not taken until the
//   final step has loaded the output register and the sequencer is idle again.
//   The single multiplier, used three times per section, sets that pace.
// Reset: coefficients and all section delays read as zero; delay rows carry a
//   valid bit each, so there is no clearing pass.
// Stall: the result sits in the output register while out_ch.ready is low; the
//   next sample may be taken and computed meanwhile, and the sequencer waits at
//   its final step until the output register is free.
`timescale 1ns / 1ps

module three_band_iir_crossover_top #(
  parameter int COEF_FRAC_BITS       = 30,
  parameter int SECTIONS_PER_CASCADE = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  tbcx_in_if.sink                                in_ch,
  tbcx_out_if.source                             out_ch,
  input  logic                                   cfg_we,
  input  logic [tbcx_pkg::REG_IDX_W-1:0]         cfg_idx,
  input  logic [tbcx_pkg::COEF_BITS-1:0]         cfg_wdata
);

  localparam int SB           = tbcx_pkg::SAMPLE_BITS;
  localparam int DB           = tbcx_pkg::DELAY_BITS;
  localparam int TB           = tbcx_pkg::TERM_BITS;
  localparam int PB           = tbcx_pkg::PROD_BITS;
  localparam int CB           = tbcx_pkg::COEF_BITS;
  localparam int DFRAC_CAND   = 46 - SB;
  localparam int DFRAC        = (COEF_FRAC_BITS < DFRAC_CAND) ? COEF_FRAC_BITS : DFRAC_CAND;
  localparam int PROD_SHIFT   = COEF_FRAC_BITS - DFRAC;
  localparam int NUM_SECTIONS = 4 * SECTIONS_PER_CASCADE;
  localparam int SEC_W        = $clog2(NUM_SECTIONS);
  localparam int K_W          = $clog2(SECTIONS_PER_CASCADE);

  localparam logic signed [PB-1:0] TERM_HI = 56'sh4_0000_0000_0000;
  localparam logic signed [PB-1:0] TERM_LO = -TERM_HI;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_P0, ST_Y, ST_M1, ST_M2, ST_WR, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    CASC_LOW_LP, CASC_MID_HP, CASC_MID_LP, CASC_HIGH_HP
  } casc_t;

  // Saturate a difference to the delay range
  function automatic logic signed [DB-1:0] sat_delay(input logic signed [DB+6:0] v);
    logic signed [DB+6:0] hi;
    logic signed [DB+6:0] lo;
    hi = (DB+7)'(48'sh7FFF_FFFF_FFFF);
    lo = (DB+7)'(48'sh8000_0000_0000);
    if (v > hi) return DB'(hi);
    else if (v < lo) return DB'(lo);
    else return DB'(v);
  endfunction

  // Saturate a scaled sum to the sample range
  function automatic logic signed [SB-1:0] sat_sample(input logic signed [TB:0] v);
    logic signed [TB:0] hi;
    logic signed [TB:0] lo;
    hi = (TB+1)'(24'sh7F_FFFF);
    lo = (TB+1)'(24'sh80_0000);
    if (v > hi) return SB'(hi);
    else if (v < lo) return SB'(lo);
    else return SB'(v);
  endfunction

  // Coefficient registers
  logic signed [CB-1:0] coef_r [tbcx_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tbcx_pkg::NUM_REGS; i++) coef_r[i] <= '0;
    end else if (cfg_we) begin
      coef_r[cfg_idx] <= cfg_wdata;
    end
  end

  // Sequencer and datapath registers
  state_t               state_r;
  casc_t                casc_r;
  logic [SEC_W-1:0]     sec_r;
  logic [K_W-1:0]       k_r;
  logic [NUM_SECTIONS-1:0] vld_r;
  logic                 rd_vld_r;
  logic [2*DB-1:0]      rd_q_r;
  logic [2*DB-1:0]      delay_mem_r [NUM_SECTIONS];
  logic signed [SB-1:0] x_r;
  logic signed [SB-1:0] cur_r;
  logic signed [SB-1:0] y_r;
  logic signed [SB-1:0] low_q_r;
  logic signed [SB-1:0] mid_q_r;
  logic signed [TB-1:0] p0_r;
  logic signed [TB+1:0] acc_r;
  logic signed [DB-1:0] z1n_r;
  logic signed [PB-1:0] prod_r;
  logic                 out_valid_r;
  logic signed [SB-1:0] out_low_r;
  logic signed [SB-1:0] out_mid_r;
  logic signed [SB-1:0] out_high_r;

  // Coefficients of the running cascade
  logic signed [CB-1:0] b0;
  logic signed [CB-1:0] a1;
  logic signed [CB-1:0] a2;
  logic                 hp;

  always_comb begin
    unique case (casc_r)
      CASC_LOW_LP:  b0 = coef_r[tbcx_pkg::REG_LOW_LP_GAIN];
      CASC_MID_HP:  b0 = coef_r[tbcx_pkg::REG_LOW_HP_GAIN];
      CASC_MID_LP:  b0 = coef_r[tbcx_pkg::REG_HIGH_LP_GAIN];
      CASC_HIGH_HP: b0 = coef_r[tbcx_pkg::REG_HIGH_HP_GAIN];
    endcase
  end

  assign a1 = (casc_r == CASC_MID_LP || casc_r == CASC_HIGH_HP) ?
              coef_r[tbcx_pkg::REG_HIGH_FB1] : coef_r[tbcx_pkg::REG_LOW_FB1];
  assign a2 = (casc_r == CASC_MID_LP || casc_r == CASC_HIGH_HP) ?
              coef_r[tbcx_pkg::REG_HIGH_FB2] : coef_r[tbcx_pkg::REG_LOW_FB2];
  assign hp = (casc_r == CASC_MID_HP) || (casc_r == CASC_HIGH_HP);

  // Shared multiplier: b0*x in RD, a1*y in M1, a2*y in M2
  logic signed [CB-1:0] mul_a;
  logic signed [SB-1:0] mul_b;

  always_comb begin
    mul_a = b0;
    mul_b = y_r;
    priority if (state_r == ST_RD) begin
      mul_b = cur_r;
    end else if (state_r == ST_M1) begin
      mul_a = a1;
    end else if (state_r == ST_M2) begin
      mul_a = a2;
    end else begin
      mul_a = b0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Product scaled to delay fraction and clamped
  logic signed [PB-1:0] prod_sh;
  logic signed [TB-1:0] term_w;

  always_comb begin
    prod_sh = prod_r >>> PROD_SHIFT;
    if (prod_sh > TERM_HI) term_w = TB'(TERM_HI);
    else if (prod_sh < TERM_LO) term_w = TB'(TERM_LO);
    else term_w = TB'(prod_sh);
  end

  // Delay row fields; rows never written read as zero
  logic signed [DB-1:0] z1;
  logic signed [DB-1:0] z2;

  assign z1 = rd_vld_r ? $signed(rd_q_r[DB-1:0])    : '0;
  assign z2 = rd_vld_r ? $signed(rd_q_r[2*DB-1:DB]) : '0;

  // Section arithmetic
  logic signed [TB:0]   ysum;
  logic signed [TB:0]   yshift;
  logic signed [TB:0]   p0x2;
  logic signed [TB:0]   p1;
  logic signed [DB+6:0] nz1;
  logic signed [DB+6:0] nz2;

  assign ysum   = (TB+1)'(p0_r) + (TB+1)'(z1);
  assign yshift = ysum >>> DFRAC;
  assign p0x2   = (TB+1)'(p0_r) <<< 1;
  assign p1     = hp ? -p0x2 : p0x2;
  assign nz1    = (DB+7)'(acc_r) - (DB+7)'(term_w);
  assign nz2    = (DB+7)'(p0_r) - (DB+7)'(term_w);

  // Delay memory: one row {z2, z1} per section
  always_ff @(posedge clk) begin
    if (state_r == ST_WR) begin
      delay_mem_r[sec_r] <= {sat_delay(nz2), z1n_r};
    end
    if (state_r == ST_RD) begin
      rd_q_r <= delay_mem_r[sec_r];
    end
  end

  logic last_k;
  logic out_free;

  assign last_k   = (k_r == K_W'(SECTIONS_PER_CASCADE - 1));
  assign out_free = !out_valid_r || out_ch.ready;

  // Sequencer, section state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      casc_r      <= CASC_LOW_LP;
      sec_r       <= '0;
      k_r         <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output valid: set when the final step loads, cleared on transfer
      if (state_r == ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            x_r     <= in_ch.audio_in;
            cur_r   <= in_ch.audio_in;
            casc_r  <= CASC_LOW_LP;
            sec_r   <= '0;
            k_r     <= '0;
            state_r <= ST_RD;
          end
        end
        ST_RD: begin
          rd_vld_r <= vld_r[sec_r];
          state_r  <= ST_P0;
        end
        ST_P0: begin
          p0_r    <= term_w;
          state_r <= ST_Y;
        end
        ST_Y: begin
          y_r     <= sat_sample(yshift);
          acc_r   <= (TB+2)'(p1) + (TB+2)'(z2);
          state_r <= ST_M1;
        end
        ST_M1: begin
          state_r <= ST_M2;
        end
        ST_M2: begin
          z1n_r   <= sat_delay(nz1);
          state_r <= ST_WR;
        end
        ST_WR: begin
          vld_r[sec_r] <= 1'b1;
          if (last_k) begin
            // cascade boundary: pick the next cascade's input
            if (casc_r == CASC_LOW_LP) low_q_r <= y_r;
            if (casc_r == CASC_MID_LP) mid_q_r <= y_r;
            cur_r  <= (casc_r == CASC_MID_HP || casc_r == CASC_HIGH_HP) ? y_r : x_r;
            k_r    <= '0;
            casc_r <= casc_t'(casc_r + 2'd1);
          end else begin
            cur_r <= y_r;
            k_r   <= k_r + 1'b1;
          end
          if (sec_r == SEC_W'(NUM_SECTIONS - 1)) begin
            state_r <= ST_OUT;
          end else begin
            sec_r   <= sec_r + 1'b1;
            state_r <= ST_RD;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_low_r   <= low_q_r;
            out_mid_r   <= mid_q_r;
            out_high_r  <= cur_r;
            state_r     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.low_band  = out_low_r;
  assign out_ch.mid_band  = out_mid_r;
  assign out_ch.high_band = out_high_r;

endmodule

>>> design/tbcx_checker.sv
// Port-level checker for the three-band crossover and its bind to the top level.
`timescale 1ns / 1ps
`include "three_band_iir_crossover_top_macros.svh"

module tbcx_checker (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    in_valid,
  input logic                                    in_ready,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic signed [tbcx_pkg::SAMPLE_BITS-1:0] low_band,
  input logic signed [tbcx_pkg::SAMPLE_BITS-1:0] mid_band,
  input logic signed [tbcx_pkg::SAMPLE_BITS-1:0] high_band
);

  // a stalled result keeps its bands
  `TBCX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(low_band) && $stable(mid_band) && $stable(high_band), "stalled result changed")

  // the block goes busy right after taking a sample
  `TBCX_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready stayed high after a sample transfer")

  // a new result only comes out of a busy sequencer
  `TBCX_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(!in_ready), "result appeared while idle")

endmodule

bind three_band_iir_crossover_top tbcx_checker u_tbcx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .low_band  (out_ch.low_band),
  .mid_band  (out_ch.mid_band),
  .high_band (out_ch.high_band)
);
